@@ design/svf_pkg.sv @@
package svf_pkg;

   // Controller states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_HIGH   = 7'b0000010,
      ST_MUL_HF = 7'b0000100,
      ST_BAND   = 7'b0001000,
      ST_MUL_BF = 7'b0010000,
      ST_LOW    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } svf_state_type;

   // Commands from the controller to the datapath, valid for one cycle each.
   typedef struct packed {
      logic take;       // capture the input word
      logic mul_en;     // register a new product
      logic mul_high;   // multiplier operand is highpass, else bandpass state
      logic mul_damp;   // multiplier coefficient is damping, else tuning
      logic high_en;    // form the highpass tap
      logic band_en;    // form and store the bandpass tap
      logic low_en;     // form and store the lowpass tap
      logic out_load;   // load the result register
   } svf_cmd_type;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_TUNING = 2'd0;
   localparam logic [1:0] REG_DAMPING = 2'd1;
   localparam logic [1:0] REG_SELECT = 2'd2;

   // Output selection codes.
   localparam logic [2:0] SEL_BYPASS = 3'd0;
   localparam logic [2:0] SEL_LOWPASS = 3'd1;
   localparam logic [2:0] SEL_HIGHPASS = 3'd2;
   localparam logic [2:0] SEL_BANDPASS = 3'd3;
   localparam logic [2:0] SEL_BANDSTOP = 3'd4;

   // sqrt(2) in Q2.30, rounded.
   localparam logic signed [63:0] SQRT2_Q30 = 64'sd1518500250;

endpackage

@@ design/svf_ctrl.sv @@
module svf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output svf_pkg::svf_cmd_type cmd
);
   import svf_pkg::*;

   svf_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   // A new word may enter while the previous result is being handed over.
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_HIGH;
         ST_HIGH:   state_in = ST_MUL_HF;
         ST_MUL_HF: state_in = ST_BAND;
         ST_BAND:   state_in = ST_MUL_BF;
         ST_MUL_BF: state_in = ST_LOW;
         ST_LOW:    state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = accept ? ST_HIGH : ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.take     = accept;
      cmd.mul_en   = accept || (state_ff == ST_MUL_HF) || (state_ff == ST_MUL_BF);
      cmd.mul_high = (state_ff == ST_MUL_HF);
      cmd.mul_damp = !((state_ff == ST_MUL_HF) || (state_ff == ST_MUL_BF));
      cmd.high_en  = (state_ff == ST_HIGH);
      cmd.band_en  = (state_ff == ST_BAND);
      cmd.low_en   = (state_ff == ST_LOW);
      cmd.out_load = (state_ff == ST_DONE) && out_free;
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state register is not one-hot");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while a word is still pending");

   a_accept_state: assert property (@(posedge clock) disable iff (reset)
      accept |-> ((state_ff == ST_IDLE) || (state_ff == ST_DONE)))
      else $error("input accepted while a sample is in flight");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_HIGH))
      else $error("accepted sample did not start processing");

endmodule

@@ design/svf_datapath.sv @@
module svf_datapath #(
   parameter int SAMPLE_WIDTH    = 20,
   parameter int COEFF_FRAC_BITS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  svf_pkg::svf_cmd_type                cmd,
   input  logic                                csr_write,
   input  logic [1:0]                          csr_index,
   input  logic [COEFF_FRAC_BITS:0]            csr_wdata,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample_in,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_selected_out,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_lowpass_out,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_highpass_out,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_bandpass_out,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_bandstop_out
);
   import svf_pkg::*;

   localparam int CW = COEFF_FRAC_BITS + 1;
   localparam int PW = SAMPLE_WIDTH + CW + 1;
   localparam int AW = SAMPLE_WIDTH + 3;
   localparam logic signed [PW-1:0] RoundHalf =
      {{(PW-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1);
   localparam logic signed [AW-1:0] SatMax = {{4{1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [AW-1:0] SatMin = {{4{1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [CW-1:0] TuningReset = {{(CW-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 2);
   localparam logic signed [63:0] DampingWide =
      (SQRT2_Q30 + (64'sd1 <<< (29 - COEFF_FRAC_BITS))) >>> (30 - COEFF_FRAC_BITS);
   localparam logic [CW-1:0] DampingReset = DampingWide[CW-1:0];

   function automatic logic signed [AW-1:0] extend(input logic signed [SAMPLE_WIDTH-1:0] v);
      return {{3{v[SAMPLE_WIDTH-1]}}, v};
   endfunction

   // Round to nearest with ties toward plus infinity, then drop the fraction.
   function automatic logic signed [AW-1:0] round_prod(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = (p + RoundHalf) >>> COEFF_FRAC_BITS;
      return s[AW-1:0];
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [AW-1:0] v);
      logic signed [SAMPLE_WIDTH-1:0] r;
      r = v[SAMPLE_WIDTH-1:0];
      if (v > SatMax) r = SatMax[SAMPLE_WIDTH-1:0];
      else if (v < SatMin) r = SatMin[SAMPLE_WIDTH-1:0];
      return r;
   endfunction

   logic [CW-1:0]                    tuning_ff;
   logic [CW-1:0]                    damping_ff;
   logic [2:0]                       select_ff;
   logic signed [SAMPLE_WIDTH-1:0]   x_ff;
   logic signed [PW-1:0]             prod_ff, prod_in;
   logic signed [SAMPLE_WIDTH-1:0]   high_ff, high_in;
   logic signed [SAMPLE_WIDTH-1:0]   band_ff, band_in;
   logic signed [SAMPLE_WIDTH-1:0]   low_ff, low_in;
   logic signed [SAMPLE_WIDTH-1:0]   notch_in, sel_in;
   logic signed [SAMPLE_WIDTH-1:0]   mul_a;
   logic [CW-1:0]                    mul_c;
   logic signed [AW-1:0]             rounded;

   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_ff  <= TuningReset;
         damping_ff <= DampingReset;
         select_ff  <= SEL_BYPASS;
      end else if (csr_write) begin
         if (csr_index == REG_TUNING) tuning_ff <= csr_wdata;
         if (csr_index == REG_DAMPING) damping_ff <= csr_wdata;
         if (csr_index == REG_SELECT) select_ff <= csr_wdata[2:0];
      end
   end

   // One shared multiplier serves the damping and both tuning products.
   assign mul_a   = cmd.mul_high ? high_ff : band_ff;
   assign mul_c   = cmd.mul_damp ? damping_ff : tuning_ff;
   assign prod_in = PW'(mul_a) * PW'($signed({1'b0, mul_c}));
   assign rounded = round_prod(prod_ff);

   assign high_in  = sat(extend(x_ff) - rounded - extend(low_ff));
   assign band_in  = sat(rounded + extend(band_ff));
   assign low_in   = sat(rounded + extend(low_ff));
   assign notch_in = sat(extend(low_ff) + extend(high_ff));

   always_comb begin
      unique case (select_ff)
         SEL_BYPASS:   sel_in = x_ff;
         SEL_LOWPASS:  sel_in = low_ff;
         SEL_HIGHPASS: sel_in = high_ff;
         SEL_BANDPASS: sel_in = band_ff;
         SEL_BANDSTOP: sel_in = notch_in;
         default:      sel_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
         low_ff  <= '0;
      end else begin
         if (cmd.band_en) band_ff <= band_in;
         if (cmd.low_en) low_ff <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) x_ff <= req_sample_in;
      if (cmd.mul_en) prod_ff <= prod_in;
      if (cmd.high_en) high_ff <= high_in;
      if (cmd.out_load) begin
         rsp_selected_out <= sel_in;
         rsp_lowpass_out  <= low_ff;
         rsp_highpass_out <= high_ff;
         rsp_bandpass_out <= band_ff;
         rsp_bandstop_out <= notch_in;
      end
   end

endmodule

@@ design/state_variable_filter.sv @@
// State-variable filter, one signed audio sample per word.
// Input channel req_valid/req_ready carries req_sample_in. The result channel
// rsp_valid/rsp_ready carries the selected tap and the lowpass, highpass,
// bandpass and bandstop taps of that sample, all saturated.
// The configuration channel csr_valid/csr_ready writes the tuning
// coefficient (index 0), the damping (index 1) and the output selection
// (index 2); other indexes are ignored. Write it only while the filter is idle.
// Each sample passes through one shared multiplier three times, each product
// followed by a rounding and saturating add, forming the highpass, bandpass
// and lowpass taps in turn; a new word is taken only once the last is through.
// The result sits in an output register; the next sample is accepted and
// computed while it waits. If the receiver stalls, the finished sample holds
// in the controller's last state and no further word is taken until the
// result register frees up.
// Reset clears the filter state and restores tuning 0.25, damping sqrt(2) and
// bypass selection.
module state_variable_filter #(
   parameter int SAMPLE_WIDTH    = 20,
   parameter int COEFF_FRAC_BITS = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_selected_out,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_lowpass_out,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_highpass_out,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_bandpass_out,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_bandstop_out,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [COEFF_FRAC_BITS:0]        csr_wdata
);
   import svf_pkg::*;

   svf_cmd_type cmd;

   assign csr_ready = 1'b1;

   svf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   svf_datapath #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sample_in    (req_sample_in),
      .rsp_selected_out (rsp_selected_out),
      .rsp_lowpass_out  (rsp_lowpass_out),
      .rsp_highpass_out (rsp_highpass_out),
      .rsp_bandpass_out (rsp_bandpass_out),
      .rsp_bandstop_out (rsp_bandstop_out)
   );

endmodule

@@ sim/state_variable_filter_tb.sv @@
module state_variable_filter_tb;
   import svf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW = 20;
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SW - 1)) - 1;
   localparam longint SAMPLE_MIN = -(64'sd1 <<< (SW - 1));
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic signed [SW-1:0] selected;
      logic signed [SW-1:0] lowpass;
      logic signed [SW-1:0] highpass;
      logic signed [SW-1:0] bandpass;
      logic signed [SW-1:0] bandstop;
   } taps_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SW-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_selected_out;
   logic signed [SW-1:0] rsp_lowpass_out;
   logic signed [SW-1:0] rsp_highpass_out;
   logic signed [SW-1:0] rsp_bandpass_out;
   logic signed [SW-1:0] rsp_bandstop_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Filter coefficients and integrators as the block should hold them.
   logic [15:0] tuning = 16'd8192;
   logic [15:0] damping = 16'd46341;
   logic [2:0] tap_select = SEL_BYPASS;
   longint low_acc = 0;
   longint band_acc = 0;

   logic signed [SW-1:0] pending_samples[$];
   taps_type expected_taps[$];

   int errors = 0;
   int samples_sent = 0;
   int taps_checked = 0;
   int settings_run = 0;

   int burst_left = 1;
   int gap_left = 0;
   logic drain_hold = 1'b0;

   int stall_mode = 0;
   int mode_left = 0;
   int stall_period = 2;
   int cycle_count = 0;

   state_variable_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_selected_out(rsp_selected_out),
      .rsp_lowpass_out(rsp_lowpass_out),
      .rsp_highpass_out(rsp_highpass_out),
      .rsp_bandpass_out(rsp_bandpass_out),
      .rsp_bandstop_out(rsp_bandstop_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clip(input longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
   endfunction

   // Q1.15 product, rounded half up; the arithmetic shift floors.
   function automatic longint coeff_product(input longint a, input logic [15:0] c);
      longint p;
      p = a * longint'({48'd0, c}) + 64'sd16384;
      return p >>> 15;
   endfunction

   function automatic taps_type filter_sample(input logic signed [SW-1:0] x_in);
      longint x, high, band, low, notch, sel;
      taps_type t;
      x = x_in;
      high = clip(x - coeff_product(band_acc, damping) - low_acc);
      band = clip(coeff_product(high, tuning) + band_acc);
      low = clip(coeff_product(band, tuning) + low_acc);
      notch = clip(low + high);
      band_acc = band;
      low_acc = low;
      case (tap_select)
         SEL_BYPASS:   sel = x;
         SEL_LOWPASS:  sel = low;
         SEL_HIGHPASS: sel = high;
         SEL_BANDPASS: sel = band;
         SEL_BANDSTOP: sel = notch;
         default:      sel = 0;
      endcase
      t.selected = sel[SW-1:0];
      t.lowpass = low[SW-1:0];
      t.highpass = high[SW-1:0];
      t.bandpass = band[SW-1:0];
      t.bandstop = notch[SW-1:0];
      return t;
   endfunction

   function automatic void check_tap(input string name, input logic signed [SW-1:0] exp_v,
                                     input logic signed [SW-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   function automatic logic [15:0] pick_coeff();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 4096));
         default: return 16'($urandom);
      endcase
   endfunction

   // Sender: bursts of words with random gaps, sometimes holding off until the
   // filter has handed back every outstanding result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_taps.push_back(filter_sample(req_sample_in));
            samples_sent++;
         end
         if (!req_valid || req_ready) begin
            if (drain_hold && expected_taps.size() == 0)
               drain_hold = 1'b0;
            if (gap_left != 0 || drain_hold || pending_samples.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left != 0)
                  gap_left--;
            end else begin
               req_valid <= 1'b1;
               req_sample_in <= pending_samples.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
                  if ($urandom_range(0, 15) == 0)
                     drain_hold = 1'b1;
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Receiver: checks each result word and stalls on a changing pattern.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_taps.size() == 0) begin
            $error("result word arrived with no sample outstanding");
            errors++;
         end else begin
            taps_type t;
            t = expected_taps.pop_front();
            check_tap("selected_out", t.selected, rsp_selected_out);
            check_tap("lowpass_out", t.lowpass, rsp_lowpass_out);
            check_tap("highpass_out", t.highpass, rsp_highpass_out);
            check_tap("bandpass_out", t.bandpass, rsp_bandpass_out);
            check_tap("bandstop_out", t.bandstop, rsp_bandstop_out);
            taps_checked++;
         end
      end
      cycle_count++;
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 120);
         stall_period = $urandom_range(2, 9);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (cycle_count % stall_period == 0);
         default: rsp_ready <= (mode_left < 5);
      endcase
   end

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         REG_TUNING:  tuning = data;
         REG_DAMPING: damping = data;
         REG_SELECT:  tap_select = data[2:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued sample has gone in and its result has come back.
   task automatic settle();
      while (pending_samples.size() != 0 || req_valid || expected_taps.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      settings_run++;
   endtask

   initial begin
      int remaining, len, mode, k, random_sent;
      logic signed [SW-1:0] level, v;
      random_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients, full-scale steps into saturation.
      pending_samples = '{20'sd0, 20'sd524287, 20'sd524287, -20'sd524288, -20'sd524288,
                          20'sd1, -20'sd1, 20'sd0};
      settle();

      // Tuning near 2 and no damping: the loop runs away and saturates.
      write_reg(REG_TUNING, 16'hFFFF);
      write_reg(REG_DAMPING, 16'h0000);
      write_reg(REG_SELECT, {13'd0, SEL_BANDSTOP});
      pending_samples = '{20'sd524287, -20'sd524288, 20'sd524287, -20'sd524288, 20'sd0};
      settle();

      // Zero tuning freezes the integrators.
      write_reg(REG_TUNING, 16'h0000);
      write_reg(REG_DAMPING, 16'hFFFF);
      write_reg(REG_SELECT, {13'd0, SEL_HIGHPASS});
      pending_samples = '{20'sd12345, -20'sd524288, 20'sd524287};
      settle();

      write_reg(REG_TUNING, 16'd8192);
      write_reg(REG_SELECT, {13'd0, SEL_BANDPASS});
      pending_samples = '{20'sd300000, -20'sd7};
      settle();

      // Upper data bits of the select write must be dropped.
      write_reg(REG_SELECT, 16'hFFF9);
      pending_samples = '{20'sd100000, 20'sd100000};
      settle();

      // An unused select code gives zero; index 3 changes nothing.
      write_reg(REG_SELECT, 16'h0005);
      write_reg(REG_UNUSED, 16'hFFFF);
      pending_samples = '{-20'sd200000, 20'sd5};
      settle();

      write_reg(REG_SELECT, 16'h0007);
      pending_samples = '{20'sd42};
      settle();

      while (random_sent < 2000) begin
         write_reg(REG_TUNING, pick_coeff());
         write_reg(REG_DAMPING, ($urandom_range(0, 5) == 0) ? 16'd46341 : pick_coeff());
         write_reg(REG_SELECT, {13'($urandom), 3'($urandom_range(0, 7))});
         if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 16'($urandom));
         remaining = $urandom_range(100, 230);
         while (remaining > 0) begin
            len = $urandom_range(1, 16);
            if (len > remaining)
               len = remaining;
            mode = $urandom_range(0, 4);
            level = SW'($urandom);
            for (k = 0; k < len; k++) begin
               case (mode)
                  0: v = level;
                  1: v = SW'($urandom);
                  2: v = SW'($urandom_range(0, 511) - 256);
                  3: v = k[0] ? SW'(SAMPLE_MAX) : SW'(SAMPLE_MIN);
                  default: v = level + SW'($urandom_range(0, 63));
               endcase
               pending_samples.push_back(v);
            end
            remaining -= len;
            random_sent += len;
         end
         settle();
      end

      $display("Checked %0d result words from %0d samples over %0d coefficient settings,",
               taps_checked, samples_sent, settings_run);
      $display("with saturating steps, all select codes and an ignored register index.");
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d results still outstanding.", expected_taps.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
